### sv/tsbs_pkg.sv
// shared types and constants of the trial sequencer
`default_nettype none
package tsbs_pkg;

  // datapath word width of the running totals and scores
  localparam int DATA_W = 32;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE = 4'd1;
  localparam logic [CFG_DATA_W-1:0] WARMUP_RESET  = 16'd500;
  localparam logic [CFG_DATA_W-1:0] MEASURE_RESET = 16'd1000;

  // command codes, code 3 acts as poll
  localparam logic [1:0] CMD_POLL  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_ABORT = 2'd2;

  // trial phase codes
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WARM = 2'd1,
    PH_MEAS = 2'd2
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic eval;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/tsbs_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module tsbs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tsbs_pkg::DATA_W-1:0]  dividend,
  input  logic [tsbs_pkg::DATA_W-1:0]  divisor,
  output logic                         done,
  output logic [tsbs_pkg::DATA_W-1:0]  quotient
);
  import tsbs_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              qbit;
  logic [DATA_W-1:0] rem_next;

  // one shift and trial subtract
  always_comb begin
    trial    = {rem, quo[DATA_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = ~diff[DATA_W];
    rem_next = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CNT_W'(DATA_W);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DATA_W-2:0], qbit};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

### sv/tsbs_dp.sv
// datapath: item capture, window deltas, trial scoring and run state
`default_nettype none
module tsbs_dp #(
  parameter int MAX_CANDIDATES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tsbs_pkg::ctrl_cmd_t            cmd,
  output tsbs_pkg::dp_stat_t             stat,
  // configuration
  input  logic                           cfg_we,
  input  logic [tsbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsbs_pkg::CFG_DATA_W-1:0] cfg_data,
  // input item
  input  logic [1:0]                     command,
  input  logic [31:0]                    now_ms,
  input  logic [4:0]                     candidate_count,
  input  logic                           loaded,
  input  logic                           loading,
  input  logic                           patch_changed,
  input  logic                           playing,
  input  logic                           overrun_stop,
  input  logic                           auto_request,
  input  logic [31:0]                    total_ticks,
  input  logic [31:0]                    total_blocks,
  input  logic [31:0]                    total_overruns,
  // result item
  output logic                           apply_valid,
  output logic [3:0]                     apply_index,
  output logic                           copy_back,
  output logic                           silence,
  output logic [1:0]                     phase,
  output logic                           announce_done,
  output logic [3:0]                     best_index,
  output logic [31:0]                    best_overrun_score,
  output logic [31:0]                    best_ticks_score
);
  import tsbs_pkg::*;

  localparam int CNTW = $clog2(MAX_CANDIDATES + 1);
  localparam int IW   = $clog2(MAX_CANDIDATES);

  // configuration registers
  logic [CFG_DATA_W-1:0] warmup_window_ms;
  logic [CFG_DATA_W-1:0] measure_window_ms;

  // captured item
  logic [1:0]        cmd_q;
  logic [DATA_W-1:0] now_q;
  logic [4:0]        cnt_q;
  logic              loaded_q;
  logic              loading_q;
  logic              pchg_q;
  logic              playing_q;
  logic              ostop_q;
  logic              areq_q;
  logic [DATA_W-1:0] tt_q;
  logic [DATA_W-1:0] tb_q;
  logic [DATA_W-1:0] to_q;

  // evaluated deltas
  logic              warm_ok;
  logic              meas_ok;
  logic              blocks_zero;
  logic [DATA_W-1:0] ticks_d;
  logic [DATA_W-1:0] blocks_d;
  logic [DATA_W-1:0] ovr_d;

  // run state
  phase_t            trial_phase;
  logic [CNTW-1:0]   count_of_candidates;
  logic [CNTW-1:0]   current_trial;
  logic [IW-1:0]     best_trial;
  logic [DATA_W-1:0] best_overruns_kept;
  logic [DATA_W-1:0] best_ticks_kept;
  logic [DATA_W-1:0] window_start;
  logic [DATA_W-1:0] ticks_baseline;
  logic [DATA_W-1:0] blocks_baseline;
  logic [DATA_W-1:0] overruns_baseline;
  logic              auto_run;
  logic              overrun_latch;
  logic              silence_flag;

  // next run state
  phase_t            trial_phase_next;
  logic [CNTW-1:0]   count_of_candidates_next;
  logic [CNTW-1:0]   current_trial_next;
  logic [IW-1:0]     best_trial_next;
  logic [DATA_W-1:0] best_overruns_kept_next;
  logic [DATA_W-1:0] best_ticks_kept_next;
  logic [DATA_W-1:0] window_start_next;
  logic [DATA_W-1:0] ticks_baseline_next;
  logic [DATA_W-1:0] blocks_baseline_next;
  logic [DATA_W-1:0] overruns_baseline_next;
  logic              auto_run_next;
  logic              overrun_latch_next;
  logic              silence_flag_next;

  // result pulses
  logic              apply_valid_next;
  logic [IW-1:0]     apply_idx_next;
  logic              copy_next;
  logic              announce_next;
  logic [IW-1:0]     apply_idx;

  // helpers
  logic              running_ok;
  logic              do_start;
  logic              auto_path;
  logic              do_score;
  logic [DATA_W-1:0] score_avg;
  logic [DATA_W-1:0] score_ovr;
  logic [CNTW-1:0]   cnt_cl;
  logic [CNTW-1:0]   trial_inc;
  logic              better;
  logic              ann;
  logic              is_idle;

  // divider
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  tsbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (ticks_d),
    .divisor  (blocks_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration writes, unknown indices dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_window_ms  <= WARMUP_RESET;
      measure_window_ms <= MEASURE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WARMUP) warmup_window_ms <= cfg_data;
      if (cfg_index == REG_MEASURE) measure_window_ms <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_q     <= command;
      now_q     <= now_ms;
      cnt_q     <= candidate_count;
      loaded_q  <= loaded;
      loading_q <= loading;
      pchg_q    <= patch_changed;
      playing_q <= playing;
      ostop_q   <= overrun_stop;
      areq_q    <= auto_request;
      tt_q      <= total_ticks;
      tb_q      <= total_blocks;
      to_q      <= total_overruns;
    end
  end

  // window elapsed checks and counter deltas
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      warm_ok     <= (now_q - window_start) >= DATA_W'(warmup_window_ms);
      meas_ok     <= (now_q - window_start) >= DATA_W'(measure_window_ms);
      ticks_d     <= tt_q - ticks_baseline;
      blocks_d    <= tb_q - blocks_baseline;
      blocks_zero <= (tb_q == blocks_baseline);
      ovr_d       <= to_q - overruns_baseline;
    end
  end

  // path decode shared by the divider request and the commit
  always_comb begin
    is_idle    = (trial_phase == PH_IDLE);
    running_ok = (cmd_q != CMD_START) && (cmd_q != CMD_ABORT) && !is_idle &&
                 loaded_q && !loading_q && !pchg_q && playing_q;
    if (32'(cnt_q) > 32'(MAX_CANDIDATES)) cnt_cl = CNTW'(MAX_CANDIDATES);
    else                                  cnt_cl = CNTW'(cnt_q);
  end

  assign stat.need_div = running_ok && (trial_phase == PH_MEAS) && meas_ok && !blocks_zero;
  assign stat.div_done = div_done;

  // next state of the run for the captured item
  always_comb begin
    trial_phase_next         = trial_phase;
    count_of_candidates_next = count_of_candidates;
    current_trial_next       = current_trial;
    best_trial_next          = best_trial;
    best_overruns_kept_next  = best_overruns_kept;
    best_ticks_kept_next     = best_ticks_kept;
    window_start_next        = window_start;
    ticks_baseline_next      = ticks_baseline;
    blocks_baseline_next     = blocks_baseline;
    overruns_baseline_next   = overruns_baseline;
    auto_run_next            = auto_run;
    overrun_latch_next       = overrun_latch | ostop_q;
    silence_flag_next        = silence_flag;
    apply_valid_next         = 1'b0;
    apply_idx_next           = '0;
    copy_next                = 1'b0;
    announce_next            = 1'b0;
    do_start                 = 1'b0;
    auto_path                = 1'b0;
    do_score                 = 1'b0;
    score_avg                = ALL_ONES;
    score_ovr                = ALL_ONES;
    trial_inc                = current_trial + CNTW'(1);
    better                   = 1'b0;
    ann                      = 1'b0;

    // command dispatch
    priority if (cmd_q == CMD_START) begin
      do_start = is_idle && loaded_q && (cnt_cl != '0);
    end else if (cmd_q == CMD_ABORT) begin
      if (!is_idle) begin
        silence_flag_next = 1'b0;
        auto_run_next     = 1'b0;
        trial_phase_next  = PH_IDLE;
        if (loaded_q) begin
          apply_valid_next = 1'b1;
          apply_idx_next   = (best_overruns_kept == ALL_ONES) ? '0 : best_trial;
        end
        copy_next = 1'b1;
      end
    end else if (is_idle) begin
      if (areq_q) begin
        auto_path = 1'b1;
        do_start  = loaded_q && (cnt_cl != '0);
      end
    end else if (!loaded_q || loading_q || pchg_q) begin
      // patch lost
      silence_flag_next = 1'b0;
      auto_run_next     = 1'b0;
      trial_phase_next  = PH_IDLE;
    end else if (!playing_q) begin
      if (overrun_latch | ostop_q) begin
        // overload stop scores the worst value
        overrun_latch_next = 1'b0;
        do_score           = 1'b1;
      end else begin
        // user stop
        silence_flag_next = 1'b0;
        auto_run_next     = 1'b0;
        trial_phase_next  = PH_IDLE;
        copy_next         = 1'b1;
      end
    end else if (trial_phase == PH_WARM) begin
      if (warm_ok) begin
        ticks_baseline_next    = tt_q;
        blocks_baseline_next   = tb_q;
        overruns_baseline_next = to_q;
        window_start_next      = now_q;
        trial_phase_next       = PH_MEAS;
      end
    end else if (trial_phase == PH_MEAS) begin
      if (meas_ok) begin
        if (blocks_zero) begin
          window_start_next = now_q;
        end else begin
          do_score  = 1'b1;
          score_avg = div_q;
          score_ovr = ovr_d;
        end
      end
    end

    // start of a run
    if (do_start) begin
      count_of_candidates_next = cnt_cl;
      current_trial_next       = '0;
      best_trial_next          = '0;
      best_ticks_kept_next     = ALL_ONES;
      best_overruns_kept_next  = ALL_ONES;
      if (cnt_cl > CNTW'(1)) silence_flag_next = 1'b1;
      apply_valid_next   = 1'b1;
      apply_idx_next     = '0;
      overrun_latch_next = 1'b0;
      if (cnt_cl == CNTW'(1)) begin
        copy_next         = 1'b1;
        silence_flag_next = 1'b0;
        auto_run_next     = 1'b0;
        trial_phase_next  = PH_IDLE;
      end else begin
        window_start_next = now_q;
        trial_phase_next  = PH_WARM;
      end
    end
    if (auto_path) auto_run_next = (trial_phase_next != PH_IDLE);

    // scoring of a finished trial
    if (do_score) begin
      better = (score_ovr < best_overruns_kept) ||
               ((score_ovr == best_overruns_kept) && (score_avg < best_ticks_kept));
      if (better) begin
        best_overruns_kept_next = score_ovr;
        best_ticks_kept_next    = score_avg;
        best_trial_next         = current_trial[IW-1:0];
      end
      current_trial_next = trial_inc;
      if (trial_inc < count_of_candidates) begin
        apply_valid_next  = 1'b1;
        apply_idx_next    = trial_inc[IW-1:0];
        window_start_next = now_q;
        trial_phase_next  = PH_WARM;
      end else begin
        ann               = auto_run;
        silence_flag_next = 1'b0;
        auto_run_next     = 1'b0;
        trial_phase_next  = PH_IDLE;
        apply_valid_next  = 1'b1;
        apply_idx_next    = best_trial_next;
        copy_next         = 1'b1;
        announce_next     = ann;
      end
    end
  end

  // run state update at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      trial_phase         <= PH_IDLE;
      count_of_candidates <= '0;
      current_trial       <= '0;
      best_trial          <= '0;
      best_overruns_kept  <= ALL_ONES;
      best_ticks_kept     <= ALL_ONES;
      window_start        <= '0;
      ticks_baseline      <= '0;
      blocks_baseline     <= '0;
      overruns_baseline   <= '0;
      auto_run            <= 1'b0;
      overrun_latch       <= 1'b0;
      silence_flag        <= 1'b0;
    end else if (cmd.commit) begin
      trial_phase         <= trial_phase_next;
      count_of_candidates <= count_of_candidates_next;
      current_trial       <= current_trial_next;
      best_trial          <= best_trial_next;
      best_overruns_kept  <= best_overruns_kept_next;
      best_ticks_kept     <= best_ticks_kept_next;
      window_start        <= window_start_next;
      ticks_baseline      <= ticks_baseline_next;
      blocks_baseline     <= blocks_baseline_next;
      overruns_baseline   <= overruns_baseline_next;
      auto_run            <= auto_run_next;
      overrun_latch       <= overrun_latch_next;
      silence_flag        <= silence_flag_next;
    end
  end

  // result pulse register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      apply_valid   <= apply_valid_next;
      apply_idx     <= apply_idx_next;
      copy_back     <= copy_next;
      announce_done <= announce_next;
    end
  end

  // state only moves at commit, so it is shown directly
  assign apply_index        = 4'(apply_idx);
  assign silence            = silence_flag;
  assign phase              = trial_phase;
  assign best_index         = 4'(best_trial);
  assign best_overrun_score = best_overruns_kept;
  assign best_ticks_score   = best_ticks_kept;

endmodule
`default_nettype wire

### sv/tsbs_ctrl.sv
// controller: sequences capture, evaluation, divide and commit of each transaction
`default_nettype none
module tsbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tsbs_pkg::dp_stat_t  stat,
  output tsbs_pkg::ctrl_cmd_t cmd
);
  import tsbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd.load_item = (state == S_IDLE) && in_valid;
    cmd.eval      = (state == S_EVAL);
    cmd.div_start = (state == S_DECIDE) && stat.need_div;
    cmd.commit    = (state == S_COMMIT) && slot_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result slot filled at commit, emptied when taken
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= stat.need_div ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          if (stat.div_done) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/trial_sequencer_best_select.sv
// top level of the trial sequencer with best-candidate selection
`default_nettype none
// Each input transaction (start, poll or abort plus player status and running totals)
// gives exactly one result transaction. The result is registered at commit, which
// waits until the output register is free. When the transaction closes a measure
// window with blocks run, the average ticks per block first comes from a restoring
// divider that yields one quotient bit a cycle. Transactions are handled one at a
// time; the next one is accepted once the previous result sits in the output
// register, even if it has not been taken yet. Configuration writes are always
// accepted and should be issued only while no transaction is in flight.
module trial_sequencer_best_select #(
  parameter int MAX_CANDIDATES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsbs_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [31:0]                     now_ms,
  input  logic [4:0]                      candidate_count,
  input  logic                            loaded,
  input  logic                            loading,
  input  logic                            patch_changed,
  input  logic                            playing,
  input  logic                            overrun_stop,
  input  logic                            auto_request,
  input  logic [31:0]                     total_ticks,
  input  logic [31:0]                     total_blocks,
  input  logic [31:0]                     total_overruns,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            apply_valid,
  output logic [3:0]                      apply_index,
  output logic                            copy_back,
  output logic                            silence,
  output logic [1:0]                      phase,
  output logic                            announce_done,
  output logic [3:0]                      best_index,
  output logic [31:0]                     best_overrun_score,
  output logic [31:0]                     best_ticks_score
);
  import tsbs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tsbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsbs_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .command            (command),
    .now_ms             (now_ms),
    .candidate_count    (candidate_count),
    .loaded             (loaded),
    .loading            (loading),
    .patch_changed      (patch_changed),
    .playing            (playing),
    .overrun_stop       (overrun_stop),
    .auto_request       (auto_request),
    .total_ticks        (total_ticks),
    .total_blocks       (total_blocks),
    .total_overruns     (total_overruns),
    .apply_valid        (apply_valid),
    .apply_index        (apply_index),
    .copy_back          (copy_back),
    .silence            (silence),
    .phase              (phase),
    .announce_done      (announce_done),
    .best_index         (best_index),
    .best_overrun_score (best_overrun_score),
    .best_ticks_score   (best_ticks_score)
  );

  // divider only started when a measure window is being scored
  a_div_start_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> stat.need_div)
    else $error("divider started without a scored window");

  // no silence once the run is back to idle
  a_idle_not_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == PH_IDLE) |-> !silence)
    else $error("silence held while idle");

  // an announcement always comes with the final apply and copy-back
  a_announce_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && announce_done |-> apply_valid && copy_back && (phase == PH_IDLE))
    else $error("announcement without final apply");

  // no transaction taken while a result is being committed
  a_commit_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !in_ready)
    else $error("commit overlaps acceptance");

endmodule
`default_nettype wire
